### src/sfp_pkg.sv
// Shared types, constants and the CRC-8 byte update for the serial frame parser.
package sfp_pkg;

    // Frame marker bytes
    localparam logic [7:0] HDR1_BYTE = 8'h55;
    localparam logic [7:0] HDR2_BYTE = 8'hAA;
    localparam logic [7:0] END1_BYTE = 8'h0D;
    localparam logic [7:0] END2_BYTE = 8'h0A;

    // Reflected CRC-8 polynomial and command register reset value
    localparam logic [7:0]  CRC_POLY    = 8'h8C;
    localparam logic [15:0] CMD_DEFAULT = 16'hA55A;

    // Result status codes
    localparam logic [2:0] STATUS_OK     = 3'd0;
    localparam logic [2:0] STATUS_HEADER = 3'd1;
    localparam logic [2:0] STATUS_CMD    = 3'd2;
    localparam logic [2:0] STATUS_ENDER  = 3'd3;
    localparam logic [2:0] STATUS_CKSUM  = 3'd4;

    // Number of payload bytes kept for the wheel speeds
    localparam int SPEED_BYTES = 8;

    typedef logic [7:0] t_byte;

    // One result item
    typedef struct packed {
        logic [2:0]         status;
        logic signed [15:0] speed_left_front;
        logic signed [15:0] speed_right_front;
        logic signed [15:0] speed_right_back;
        logic signed [15:0] speed_left_back;
        logic [7:0]         payload_length;
    } t_result;

    // Parser output towards the result register
    typedef struct packed {
        logic    valid;
        t_result result;
    } t_parse_out;

    // Fold one byte into the running CRC, one bit per step
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### src/speed_frame_parser_crc8.sv
// Top level of the serial frame parser with CRC-8 check and wheel speed decode.
// Result path: input register, combinational parse, then the result register.
// Throughput: one byte per cycle; the input register feeds the parser each cycle that
// the result register has room.
// Reset: synchronous active low; parser hunts for a header, command returns to A55A;
// the byte and configuration ports hold off while reset is low.
module speed_frame_parser_crc8 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic signed [15:0] o_speed_left_front,
    output logic signed [15:0] o_speed_right_front,
    output logic signed [15:0] o_speed_right_back,
    output logic signed [15:0] o_speed_left_back,
    output logic [7:0]         o_payload_length,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_expected_command
);

    logic [15:0]         r_cmd;
    logic                out_free;
    logic                step;
    logic [7:0]          stage_byte;
    sfp_pkg::t_parse_out parse_out;
    sfp_pkg::t_result    result;

    // Take configuration writes only out of reset
    assign o_cfg_ready = i_rst_n;

    // Command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= sfp_pkg::CMD_DEFAULT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cmd <= i_cfg_expected_command;
        end
    end

    sfp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_adv_ok  (out_free),
        .o_step    (step),
        .o_byte    (stage_byte)
    );

    sfp_parser u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_byte             (stage_byte),
        .i_expected_command (r_cmd),
        .o_out              (parse_out)
    );

    sfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (parse_out),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (result)
    );

    assign o_status            = result.status;
    assign o_speed_left_front  = result.speed_left_front;
    assign o_speed_right_front = result.speed_right_front;
    assign o_speed_right_back  = result.speed_right_back;
    assign o_speed_left_back   = result.speed_left_back;
    assign o_payload_length    = result.payload_length;

    // Status is always one of the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= sfp_pkg::STATUS_CKSUM))
        else $error("status code out of range");

    // Error results carry no speeds
    a_err_speeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != sfp_pkg::STATUS_OK) |->
        (o_speed_left_front == 16'sd0 && o_speed_right_front == 16'sd0 &&
         o_speed_right_back == 16'sd0 && o_speed_left_back == 16'sd0))
        else $error("error result carries speeds");

    // Header and command errors report no length
    a_err_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == sfp_pkg::STATUS_HEADER ||
                     o_status == sfp_pkg::STATUS_CMD)) |-> (o_payload_length == 8'd0))
        else $error("early error reports a length");

    // A result is never produced into a full, stalled result register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !parse_out.valid)
        else $error("result register overwritten");

endmodule

### src/sfp_in_reg.sv
// Input register stage: holds one received byte until the parser takes it.
module sfp_in_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_adv_ok,
    output logic        o_step,
    output logic [7:0]  o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       accept;

    // Advance into the parser whenever the result side has room; hold off during reset
    assign o_step  = r_valid && i_adv_ok;
    assign o_stall = !i_rst_n || (r_valid && !i_adv_ok);
    assign accept  = i_valid && !o_stall;
    assign o_byte  = r_byte;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_step) begin
            n_valid = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture the byte on accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule

### src/sfp_parser.sv
// Frame parser: phase tracking, running CRC, payload capture and result decode.
module sfp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic [15:0]         i_expected_command,
    output sfp_pkg::t_parse_out o_out
);

    localparam logic [3:0] PH_HUNT1   = 4'd0;
    localparam logic [3:0] PH_HUNT2   = 4'd1;
    localparam logic [3:0] PH_CMD1    = 4'd2;
    localparam logic [3:0] PH_CMD2    = 4'd3;
    localparam logic [3:0] PH_LEN     = 4'd4;
    localparam logic [3:0] PH_PAYLOAD = 4'd5;
    localparam logic [3:0] PH_CRC     = 4'd6;
    localparam logic [3:0] PH_END1    = 4'd7;
    localparam logic [3:0] PH_END2    = 4'd8;

    logic [3:0] r_phase;
    logic [3:0] n_phase;
    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic [7:0] r_length;
    logic [7:0] n_length;
    logic       r_crc_ok;
    logic       n_crc_ok;
    logic       clear_speed;
    logic       write_speed;
    logic [7:0] crc_next;
    logic [7:0] count_inc;
    sfp_pkg::t_byte r_speed [sfp_pkg::SPEED_BYTES];

    assign crc_next  = sfp_pkg::crc8_update(r_crc, i_byte);
    assign count_inc = r_count + 8'd1;

    // Decide next phase, counters and the result for the byte in hand
    always_comb begin
        n_phase     = r_phase;
        n_crc       = r_crc;
        n_count     = r_count;
        n_length    = r_length;
        n_crc_ok    = r_crc_ok;
        clear_speed = 1'b0;
        write_speed = 1'b0;
        o_out       = '0;
        case (r_phase)
            PH_HUNT2: begin
                if (i_byte != sfp_pkg::HDR2_BYTE) begin
                    n_phase             = PH_HUNT1;
                    o_out.valid         = 1'b1;
                    o_out.result.status = sfp_pkg::STATUS_HEADER;
                end else begin
                    n_crc   = crc_next;
                    n_phase = PH_CMD1;
                end
            end
            PH_CMD1: begin
                if (i_byte != i_expected_command[15:8]) begin
                    n_phase             = PH_HUNT1;
                    o_out.valid         = 1'b1;
                    o_out.result.status = sfp_pkg::STATUS_CMD;
                end else begin
                    n_crc   = crc_next;
                    n_phase = PH_CMD2;
                end
            end
            PH_CMD2: begin
                if (i_byte != i_expected_command[7:0]) begin
                    n_phase             = PH_HUNT1;
                    o_out.valid         = 1'b1;
                    o_out.result.status = sfp_pkg::STATUS_CMD;
                end else begin
                    n_crc   = crc_next;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_crc    = crc_next;
                n_length = i_byte;
                n_count  = '0;
                n_phase  = (i_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_crc       = crc_next;
                write_speed = (r_count < 8'(sfp_pkg::SPEED_BYTES));
                n_count     = count_inc;
                if (count_inc >= r_length) begin
                    n_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                n_crc_ok = (i_byte == r_crc);
                n_phase  = PH_END1;
            end
            PH_END1: begin
                if (i_byte != sfp_pkg::END1_BYTE) begin
                    n_phase                     = PH_HUNT1;
                    o_out.valid                 = 1'b1;
                    o_out.result.status         = sfp_pkg::STATUS_ENDER;
                    o_out.result.payload_length = r_length;
                end else begin
                    n_phase = PH_END2;
                end
            end
            PH_END2: begin
                n_phase                     = PH_HUNT1;
                o_out.valid                 = 1'b1;
                o_out.result.payload_length = r_length;
                if (i_byte != sfp_pkg::END2_BYTE) begin
                    o_out.result.status = sfp_pkg::STATUS_ENDER;
                end else if (!r_crc_ok) begin
                    o_out.result.status = sfp_pkg::STATUS_CKSUM;
                end else begin
                    o_out.result.status            = sfp_pkg::STATUS_OK;
                    o_out.result.speed_left_front  = {r_speed[0], r_speed[1]};
                    o_out.result.speed_right_front = {r_speed[2], r_speed[3]};
                    o_out.result.speed_right_back  = {r_speed[4], r_speed[5]};
                    o_out.result.speed_left_back   = {r_speed[6], r_speed[7]};
                end
            end
            default: begin
                // Hunting for the first header byte; stray bytes are dropped
                n_phase = PH_HUNT1;
                if (i_byte == sfp_pkg::HDR1_BYTE) begin
                    n_crc       = sfp_pkg::crc8_update(8'd0, i_byte);
                    n_count     = '0;
                    n_length    = '0;
                    n_crc_ok    = 1'b0;
                    clear_speed = 1'b1;
                    n_phase     = PH_HUNT2;
                end
            end
        endcase
        if (!i_step) begin
            o_out.valid = 1'b0;
        end
    end

    // Advance parse state on each byte taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT1;
            r_crc    <= '0;
            r_count  <= '0;
            r_length <= '0;
            r_crc_ok <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_count  <= n_count;
            r_length <= n_length;
            r_crc_ok <= n_crc_ok;
        end
    end

    // Capture the first payload bytes, clear them at each new frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < sfp_pkg::SPEED_BYTES; k++) begin
                r_speed[k] <= '0;
            end
        end else if (i_step && clear_speed) begin
            for (int k = 0; k < sfp_pkg::SPEED_BYTES; k++) begin
                r_speed[k] <= '0;
            end
        end else if (i_step && write_speed) begin
            r_speed[r_count[2:0]] <= i_byte;
        end
    end

endmodule

### src/sfp_out_reg.sv
// Result register: holds one result item until the downstream side takes it.
module sfp_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfp_pkg::t_parse_out i_in,
    input  logic                i_stall,
    output logic                o_free,
    output logic                o_valid,
    output sfp_pkg::t_result    o_result
);

    logic             r_valid;
    logic             n_valid;
    sfp_pkg::t_result r_result;

    // Room for a new result when empty or draining this cycle
    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_in.valid) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid) begin
            r_result <= i_in.result;
        end
    end

endmodule

### dv/speed_frame_parser_crc8_test.sv
// Self-checking testbench for the serial frame parser: random framed traffic, scoreboard compare.
module speed_frame_parser_crc8_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Parser phases as the predictor tracks them
    localparam logic [3:0] P_SYNC1  = 4'd0;
    localparam logic [3:0] P_SYNC2  = 4'd1;
    localparam logic [3:0] P_CMD_HI = 4'd2;
    localparam logic [3:0] P_CMD_LO = 4'd3;
    localparam logic [3:0] P_LENGTH = 4'd4;
    localparam logic [3:0] P_DATA   = 4'd5;
    localparam logic [3:0] P_CHECK  = 4'd6;
    localparam logic [3:0] P_TAIL1  = 4'd7;
    localparam logic [3:0] P_TAIL2  = 4'd8;

    // Where a generated frame gets corrupted
    typedef enum int {
        FAULT_NONE, FAULT_SYNC2, FAULT_CMD_HI, FAULT_CMD_LO, FAULT_CHECK, FAULT_TAIL1, FAULT_TAIL2
    } t_fault;

    // Frame predictor and store of pending frame results
    class t_frame_scoreboard;
        sfp_pkg::t_result pending_q[$];
        logic [15:0]      command;
        logic [3:0]       phase;
        sfp_pkg::t_byte   crc;
        sfp_pkg::t_byte   count;
        sfp_pkg::t_byte   length;
        logic [63:0]      speeds;
        bit               crc_good;
        int               mismatches;
        int               checked;
        int               by_status[5];

        function new();
            command    = sfp_pkg::CMD_DEFAULT;
            phase      = P_SYNC1;
            crc        = 8'h00;
            count      = 8'h00;
            length     = 8'h00;
            speeds     = '0;
            crc_good   = 1'b0;
            mismatches = 0;
            checked    = 0;
            foreach (by_status[k]) by_status[k] = 0;
        endfunction

        // Reflected CRC-8, LSB first, one bit per step
        static function sfp_pkg::t_byte fold_crc8(input sfp_pkg::t_byte acc,
                                                  input sfp_pkg::t_byte data);
            sfp_pkg::t_byte r;
            r = acc ^ data;
            repeat (8) begin
                r = r[0] ? ((r >> 1) ^ sfp_pkg::CRC_POLY) : (r >> 1);
            end
            return r;
        endfunction

        function void set_command(input logic [15:0] value);
            command = value;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function void close_frame(input logic [2:0] st, input bit with_speeds,
                                  input sfp_pkg::t_byte len);
            sfp_pkg::t_result r;
            r.status            = st;
            r.speed_left_front  = with_speeds ? speeds[63:48] : 16'sd0;
            r.speed_right_front = with_speeds ? speeds[47:32] : 16'sd0;
            r.speed_right_back  = with_speeds ? speeds[31:16] : 16'sd0;
            r.speed_left_back   = with_speeds ? speeds[15:0]  : 16'sd0;
            r.payload_length    = len;
            pending_q.push_back(r);
        endfunction

        // Advance the parse by one accepted byte
        function void note_byte(input sfp_pkg::t_byte b);
            case (phase)
                P_SYNC2: begin
                    if (b != sfp_pkg::HDR2_BYTE) begin
                        phase = P_SYNC1;
                        close_frame(sfp_pkg::STATUS_HEADER, 1'b0, 8'h00);
                    end else begin
                        crc   = fold_crc8(crc, b);
                        phase = P_CMD_HI;
                    end
                end
                P_CMD_HI: begin
                    if (b != command[15:8]) begin
                        phase = P_SYNC1;
                        close_frame(sfp_pkg::STATUS_CMD, 1'b0, 8'h00);
                    end else begin
                        crc   = fold_crc8(crc, b);
                        phase = P_CMD_LO;
                    end
                end
                P_CMD_LO: begin
                    if (b != command[7:0]) begin
                        phase = P_SYNC1;
                        close_frame(sfp_pkg::STATUS_CMD, 1'b0, 8'h00);
                    end else begin
                        crc   = fold_crc8(crc, b);
                        phase = P_LENGTH;
                    end
                end
                P_LENGTH: begin
                    crc    = fold_crc8(crc, b);
                    length = b;
                    count  = 8'h00;
                    phase  = (b == 8'h00) ? P_CHECK : P_DATA;
                end
                P_DATA: begin
                    crc = fold_crc8(crc, b);
                    if (count < sfp_pkg::SPEED_BYTES) speeds[63 - 8 * int'(count) -: 8] = b;
                    count = count + 8'd1;
                    if (count >= length) phase = P_CHECK;
                end
                P_CHECK: begin
                    crc_good = (b == crc);
                    phase    = P_TAIL1;
                end
                P_TAIL1: begin
                    if (b != sfp_pkg::END1_BYTE) begin
                        phase = P_SYNC1;
                        close_frame(sfp_pkg::STATUS_ENDER, 1'b0, length);
                    end else begin
                        phase = P_TAIL2;
                    end
                end
                P_TAIL2: begin
                    phase = P_SYNC1;
                    if (b != sfp_pkg::END2_BYTE) close_frame(sfp_pkg::STATUS_ENDER, 1'b0, length);
                    else if (!crc_good) close_frame(sfp_pkg::STATUS_CKSUM, 1'b0, length);
                    else close_frame(sfp_pkg::STATUS_OK, 1'b1, length);
                end
                default: begin
                    // Hunting: drop anything but the first sync byte
                    phase = P_SYNC1;
                    if (b == sfp_pkg::HDR1_BYTE) begin
                        crc      = fold_crc8(8'h00, b);
                        count    = 8'h00;
                        length   = 8'h00;
                        speeds   = '0;
                        crc_good = 1'b0;
                        phase    = P_SYNC2;
                    end
                end
            endcase
        endfunction

        // Compare one accepted result against the oldest pending one
        function void check_result(input sfp_pkg::t_result got);
            sfp_pkg::t_result want;
            if (pending_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result status=%0d len=%0d", $time, got.status,
                         got.payload_length);
                return;
            end
            want = pending_q.pop_front();
            checked++;
            by_status[want.status]++;
            if (got !== want) begin
                mismatches++;
                $display("%0t: mismatch expected st=%0d lf=%0d rf=%0d rb=%0d lb=%0d len=%0d",
                         $time, want.status, want.speed_left_front, want.speed_right_front,
                         want.speed_right_back, want.speed_left_back, want.payload_length);
                $display("%0t:          actual   st=%0d lf=%0d rf=%0d rb=%0d lb=%0d len=%0d",
                         $time, got.status, got.speed_left_front, got.speed_right_front,
                         got.speed_right_back, got.speed_left_back, got.payload_length);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [2:0]         o_status;
    logic signed [15:0] o_speed_left_front;
    logic signed [15:0] o_speed_right_front;
    logic signed [15:0] o_speed_right_back;
    logic signed [15:0] o_speed_left_back;
    logic [7:0]         o_payload_length;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [15:0]        i_cfg_expected_command = sfp_pkg::CMD_DEFAULT;

    t_frame_scoreboard sb = new();
    sfp_pkg::t_byte    payload_q[$];
    logic [15:0]       cur_cmd = sfp_pkg::CMD_DEFAULT;
    bit                no_gaps = 1'b0;
    int                stall_left = 0;
    int                frames = 0;
    int                frame_bytes = 0;
    int                cmd_writes = 0;

    speed_frame_parser_crc8 i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_rx_byte              (i_rx_byte),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_status               (o_status),
        .o_speed_left_front     (o_speed_left_front),
        .o_speed_right_front    (o_speed_right_front),
        .o_speed_right_back     (o_speed_right_back),
        .o_speed_left_back      (o_speed_left_back),
        .o_payload_length       (o_payload_length),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_expected_command (i_cfg_expected_command)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side: check each accepted item, then hold stall for a random count
    always @(posedge i_clk) begin : result_side
        sfp_pkg::t_result seen;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                seen.status            = o_status;
                seen.speed_left_front  = o_speed_left_front;
                seen.speed_right_front = o_speed_right_front;
                seen.speed_right_back  = o_speed_right_back;
                seen.speed_left_back   = o_speed_left_back;
                seen.payload_length    = o_payload_length;
                sb.check_result(seen);
                stall_left = no_gaps ? 0 : $urandom_range(0, 10);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_stall <= (stall_left != 0);
        end
    end

    // Offer one byte after a random gap and hold it until taken
    task automatic send_byte(input sfp_pkg::t_byte b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_byte(b);
    endtask

    // Hold the sender until every pending result is in and the pipeline is empty
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_command(input logic [15:0] value);
        drain_results();
        i_cfg_valid            <= 1'b1;
        i_cfg_expected_command <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_command(value);
        cur_cmd = value;
        cmd_writes++;
    endtask

    task automatic fill_payload(input int len);
        payload_q.delete();
        repeat (len) payload_q.push_back(sfp_pkg::t_byte'($urandom_range(0, 255)));
    endtask

    // Build a frame around payload_q, corrupt one byte if asked, and send it
    task automatic send_frame(input t_fault fault);
        sfp_pkg::t_byte fr[$];
        sfp_pkg::t_byte sum;
        int             idx;
        int             n;
        fr.push_back(sfp_pkg::HDR1_BYTE);
        fr.push_back(sfp_pkg::HDR2_BYTE);
        fr.push_back(cur_cmd[15:8]);
        fr.push_back(cur_cmd[7:0]);
        fr.push_back(sfp_pkg::t_byte'(payload_q.size()));
        foreach (payload_q[k]) fr.push_back(payload_q[k]);
        sum = 8'h00;
        foreach (fr[k]) sum = t_frame_scoreboard::fold_crc8(sum, fr[k]);
        fr.push_back(sum);
        fr.push_back(sfp_pkg::END1_BYTE);
        fr.push_back(sfp_pkg::END2_BYTE);
        n = fr.size();
        case (fault)
            FAULT_SYNC2:  idx = 1;
            FAULT_CMD_HI: idx = 2;
            FAULT_CMD_LO: idx = 3;
            FAULT_CHECK:  idx = n - 3;
            FAULT_TAIL1:  idx = n - 2;
            FAULT_TAIL2:  idx = n - 1;
            default:      idx = -1;
        endcase
        if (idx >= 0) begin
            fr[idx] = fr[idx] ^ sfp_pkg::t_byte'($urandom_range(1, 255));
            // Non-checksum faults: half stop at the bad byte, the rest trail on as noise
            if (fault != FAULT_CHECK && $urandom_range(0, 1) == 1) n = idx + 1;
        end
        for (int k = 0; k < n; k++) send_byte(fr[k]);
        frames++;
        frame_bytes += n;
    endtask

    // Mostly well-formed frames with random content, some broken, some line noise
    task automatic run_random(input int target);
        int     start;
        t_fault f;
        start = frame_bytes;
        while (frame_bytes - start < target) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 99) < 8) begin
                repeat ($urandom_range(1, 4)) send_byte(sfp_pkg::t_byte'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 39) == 0) fill_payload($urandom_range(9, 255));
                else fill_payload($urandom_range(0, 12));
                if ($urandom_range(0, 9) < 6) f = FAULT_NONE;
                else f = t_fault'($urandom_range(1, 6));
                send_frame(f);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle bytes, speed extremes, consumed sync, each error, short frames
        send_byte(8'h00);
        send_byte(8'hFF);
        payload_q = {8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01};
        send_frame(FAULT_NONE);
        send_byte(sfp_pkg::HDR1_BYTE);
        send_byte(sfp_pkg::HDR1_BYTE);
        send_byte(sfp_pkg::HDR2_BYTE);
        payload_q.delete();
        send_frame(FAULT_CMD_HI);
        send_frame(FAULT_CMD_LO);
        send_frame(FAULT_NONE);
        payload_q = {8'h12, 8'h34, 8'h56};
        send_frame(FAULT_NONE);
        send_frame(FAULT_CHECK);
        send_frame(FAULT_TAIL1);
        send_frame(FAULT_TAIL2);

        // Random traffic across several command settings
        run_random(250);
        drain_results();
        run_random(100);
        write_command(16'h0000);
        run_random(200);
        write_command(16'hFFFF);
        run_random(200);
        write_command({sfp_pkg::HDR1_BYTE, sfp_pkg::HDR2_BYTE});
        run_random(150);
        write_command(16'($urandom_range(0, 65535)));
        run_random(150);
        write_command(sfp_pkg::CMD_DEFAULT);
        run_random(100);

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d frames (%0d frame bytes) under %0d command writes; %0d results checked.",
                 frames, frame_bytes, cmd_writes, sb.checked);
        $display("Status mix: ok %0d, header %0d, command %0d, ender %0d, checksum %0d.",
                 sb.by_status[sfp_pkg::STATUS_OK], sb.by_status[sfp_pkg::STATUS_HEADER],
                 sb.by_status[sfp_pkg::STATUS_CMD], sb.by_status[sfp_pkg::STATUS_ENDER],
                 sb.by_status[sfp_pkg::STATUS_CKSUM]);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #5_000_000;
        $display("%0t: timeout, %0d results still pending", $time, sb.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
src/sfp_pkg.sv
src/sfp_in_reg.sv
src/sfp_parser.sv
src/sfp_out_reg.sv
src/speed_frame_parser_crc8.sv
dv/speed_frame_parser_crc8_test.sv
